### hdl/sol_pkg.sv
// Package with the shared constants, types and helpers of the self-organizing list.
`default_nettype none
package sol_pkg;

  localparam int CAPACITY = 128;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OUT_W    = 8;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    POL_KEEP      = 2'd0,
    POL_MTF       = 2'd1,
    POL_TRANSPOSE = 2'd2
  } policy_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT_DN,
    ST_SHIFT_UP,
    ST_SWAP_HI,
    ST_SWAP_LO,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  function automatic logic [OUT_W-1:0] sat8(input logic [CNT_W-1:0] v);
    logic [CNT_W+OUT_W-1:0] w;
    w = {{OUT_W{1'b0}}, v};
    return (w > (CNT_W+OUT_W)'(255)) ? {OUT_W{1'b1}} : w[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

### hdl/sol_if.sv
// Request and response channel interfaces of the self-organizing list.
`default_nettype none
interface sol_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic signed [sol_pkg::DATA_W-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface sol_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [sol_pkg::OUT_W-1:0]  comparisons;
  logic                       full_reject;
  logic [sol_pkg::OUT_W-1:0]  list_length;

  modport source (output valid, found, comparisons, full_reject, list_length, input ready);
  modport sink   (input valid, found, comparisons, full_reject, list_length, output ready);
endinterface
`default_nettype wire

### hdl/sol_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module sol_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

### hdl/sol_cfg.sv
// APB-style register port holding the reorder policy.
`default_nettype none
module sol_cfg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [1:0]  policy_o
);

  logic [1:0] policy_q, policy_d;
  logic       sel_policy;

  assign sel_policy = (paddr[2] == 1'b0);
  assign pready     = 1'b1;
  assign policy_o   = policy_q;
  assign prdata     = sel_policy ? {30'd0, policy_q} : 32'd0;

  always_comb begin
    policy_d = policy_q;
    if (psel && penable && pwrite && pready && sel_policy) begin
      policy_d = pwdata[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= sol_pkg::POL_KEEP;
    end else begin
      policy_q <= policy_d;
    end
  end

endmodule
`default_nettype wire

### hdl/sol_ctrl.sv
// Sequencer that scans, shifts and swaps list entries through the entry RAM.
`default_nettype none
module sol_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [1:0]                   policy_i,
  sol_req_if.sink                           req_i,
  sol_rsp_if.source                         rsp_o,
  output sol_pkg::mem_req_t                 mem_o,
  input  wire logic [sol_pkg::DATA_W-1:0]   rdata_i
);

  localparam int IDX_W = sol_pkg::IDX_W;
  localparam int CNT_W = sol_pkg::CNT_W;
  localparam int DATA_W = sol_pkg::DATA_W;
  localparam int OUT_W = sol_pkg::OUT_W;

  sol_pkg::state_e  state_q, state_d;
  sol_pkg::action_e op_q, op_d, in_act;
  logic [DATA_W-1:0] val_q, val_d, prev_q, prev_d;
  logic [CNT_W-1:0]  len_q, len_d, ncnt_q, ncnt_d, cmps_q, cmps_d;
  logic [IDX_W-1:0]  iss_q, iss_d, chk_q, chk_d;
  logic              rvalid_q, rvalid_d;
  logic              found_q, found_d, rej_q, rej_d;
  logic              ovalid_q, ovalid_d;
  logic              ofound_q, ofound_d, orej_q, orej_d;
  logic [OUT_W-1:0]  ocmps_q, ocmps_d, olen_q, olen_d;

  logic acc, len_full, len_zero, issue, cmp_hit, cmp_last, pos_zero, out_free;
  logic [CNT_W-1:0] chk_plus1;

  assign in_act    = sol_pkg::action_e'(req_i.action);
  assign req_i.ready = (state_q == sol_pkg::ST_IDLE);
  assign acc       = req_i.valid && req_i.ready;
  assign len_full  = (len_q == CNT_W'(sol_pkg::CAPACITY));
  assign len_zero  = (len_q == '0);
  assign issue     = (ncnt_q != '0);
  assign cmp_hit   = rvalid_q && (rdata_i == val_q);
  assign chk_plus1 = CNT_W'(chk_q) + CNT_W'(1);
  assign cmp_last  = (chk_plus1 == len_q);
  assign pos_zero  = (chk_q == '0);
  assign out_free  = !ovalid_q || rsp_o.ready;

  assign rsp_o.valid       = ovalid_q;
  assign rsp_o.found       = ofound_q;
  assign rsp_o.comparisons = ocmps_q;
  assign rsp_o.full_reject = orej_q;
  assign rsp_o.list_length = olen_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sol_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (in_act)
            sol_pkg::ACT_INSERT, sol_pkg::ACT_NOP: state_d = sol_pkg::ST_DONE;
            sol_pkg::ACT_DELETE, sol_pkg::ACT_FIND: begin
              state_d = len_zero ? sol_pkg::ST_DONE : sol_pkg::ST_SCAN;
            end
          endcase
        end
      end
      sol_pkg::ST_SCAN: begin
        if (cmp_hit) begin
          priority if (op_q == sol_pkg::ACT_DELETE) begin
            state_d = sol_pkg::ST_SHIFT_DN;
          end else if (pos_zero) begin
            state_d = sol_pkg::ST_DONE;
          end else if (policy_i == sol_pkg::POL_MTF) begin
            state_d = sol_pkg::ST_SHIFT_UP;
          end else if (policy_i == sol_pkg::POL_TRANSPOSE) begin
            state_d = sol_pkg::ST_SWAP_HI;
          end else begin
            state_d = sol_pkg::ST_DONE;
          end
        end else if (rvalid_q && cmp_last) begin
          state_d = sol_pkg::ST_DONE;
        end
      end
      sol_pkg::ST_SHIFT_DN, sol_pkg::ST_SHIFT_UP: begin
        if (!issue && !rvalid_q) begin
          state_d = sol_pkg::ST_DONE;
        end
      end
      sol_pkg::ST_SWAP_HI: state_d = sol_pkg::ST_SWAP_LO;
      sol_pkg::ST_SWAP_LO: state_d = sol_pkg::ST_DONE;
      sol_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = sol_pkg::ST_IDLE;
        end
      end
      default: state_d = sol_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op_d     = op_q;
    val_d    = val_q;
    prev_d   = prev_q;
    len_d    = len_q;
    ncnt_d   = ncnt_q;
    cmps_d   = cmps_q;
    iss_d    = iss_q;
    chk_d    = chk_q;
    rvalid_d = 1'b0;
    found_d  = found_q;
    rej_d    = rej_q;
    mem_o    = '0;
    ovalid_d = ovalid_q && !rsp_o.ready;
    ofound_d = ofound_q;
    ocmps_d  = ocmps_q;
    orej_d   = orej_q;
    olen_d   = olen_q;
    unique case (state_q)
      sol_pkg::ST_IDLE: begin
        if (acc) begin
          op_d    = in_act;
          val_d   = req_i.value;
          found_d = 1'b0;
          cmps_d  = '0;
          rej_d   = 1'b0;
          iss_d   = '0;
          chk_d   = '0;
          ncnt_d  = len_q;
          if (in_act == sol_pkg::ACT_INSERT) begin
            if (len_full) begin
              rej_d = 1'b1;
            end else begin
              mem_o.we    = 1'b1;
              mem_o.waddr = len_q[IDX_W-1:0];
              mem_o.wdata = req_i.value;
              len_d       = len_q + CNT_W'(1);
            end
          end
        end
      end
      sol_pkg::ST_SCAN: begin
        if (issue) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = iss_q;
          iss_d       = iss_q + IDX_W'(1);
          ncnt_d      = ncnt_q - CNT_W'(1);
          rvalid_d    = 1'b1;
        end
        if (rvalid_q) begin
          if (cmp_hit) begin
            found_d  = 1'b1;
            cmps_d   = chk_plus1;
            rvalid_d = 1'b0;
            if (op_q == sol_pkg::ACT_DELETE) begin
              iss_d  = chk_q + IDX_W'(1);
              ncnt_d = len_q - chk_plus1;
            end else begin
              iss_d  = chk_q - IDX_W'(1);
              ncnt_d = CNT_W'(chk_q);
            end
          end else begin
            prev_d = rdata_i;
            if (cmp_last) begin
              cmps_d   = len_q;
              rvalid_d = 1'b0;
            end else begin
              chk_d = chk_q + IDX_W'(1);
            end
          end
        end
      end
      sol_pkg::ST_SHIFT_DN: begin
        if (issue) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = iss_q;
          iss_d       = iss_q + IDX_W'(1);
          ncnt_d      = ncnt_q - CNT_W'(1);
          rvalid_d    = 1'b1;
        end
        if (rvalid_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = chk_q;
          mem_o.wdata = rdata_i;
          chk_d       = chk_q + IDX_W'(1);
        end
        if (!issue && !rvalid_q) begin
          len_d = len_q - CNT_W'(1);
        end
      end
      sol_pkg::ST_SHIFT_UP: begin
        if (issue) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = iss_q;
          iss_d       = iss_q - IDX_W'(1);
          ncnt_d      = ncnt_q - CNT_W'(1);
          rvalid_d    = 1'b1;
        end
        if (rvalid_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = chk_q;
          mem_o.wdata = rdata_i;
          chk_d       = chk_q - IDX_W'(1);
        end
        if (!issue && !rvalid_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = '0;
          mem_o.wdata = val_q;
        end
      end
      sol_pkg::ST_SWAP_HI: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = chk_q;
        mem_o.wdata = prev_q;
      end
      sol_pkg::ST_SWAP_LO: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = chk_q - IDX_W'(1);
        mem_o.wdata = val_q;
      end
      sol_pkg::ST_DONE: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ofound_d = found_q;
          ocmps_d  = sol_pkg::sat8(cmps_q);
          orej_d   = rej_q;
          olen_d   = sol_pkg::sat8(len_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sol_pkg::ST_IDLE;
      len_q    <= '0;
      ncnt_q   <= '0;
      rvalid_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      ncnt_q   <= ncnt_d;
      rvalid_q <= rvalid_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    val_q    <= val_d;
    prev_q   <= prev_d;
    cmps_q   <= cmps_d;
    iss_q    <= iss_d;
    chk_q    <= chk_d;
    found_q  <= found_d;
    rej_q    <= rej_d;
    ofound_q <= ofound_d;
    ocmps_q  <= ocmps_d;
    orej_q   <= orej_d;
    olen_q   <= olen_d;
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CNT_W'(sol_pkg::CAPACITY))
    else $error("list length exceeds capacity");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_o.we && mem_o.re) |-> (mem_o.waddr != mem_o.raddr))
    else $error("read and write hit the same entry in one cycle");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (state_q != sol_pkg::ST_IDLE))
    else $error("accepted beat did not start an operation");

  a_no_stray_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sol_pkg::ST_IDLE || state_q == sol_pkg::ST_DONE) |-> !rvalid_q)
    else $error("read data pending outside a scan or shift");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sol_pkg::ST_DONE && out_free) |=> ovalid_q)
    else $error("finished operation produced no result");
`endif

endmodule
`default_nettype wire

### hdl/self_organizing_list.sv
// Top level of the self-organizing list with move-to-front and transpose reordering.
// The request channel carries one beat per operation: action (insert, delete, find,
// or no-op) and a 32-bit signed value. Each request produces exactly one response
// beat with found, comparisons, full_reject and list_length.
// The APB port holds the reorder policy at byte address 0; write it only while idle.
// Entries live in one synchronous RAM with one write and one read port.
// Insert, no-op and a delete or find on an empty list go from acceptance to the done
// state and from there into the response register.
// Delete and find scan one entry per cycle from the front. A delete hit then shifts
// the tail down one entry per cycle; move to front shifts the head up; transpose
// swaps the hit with the entry before it.
// Only one operation is in flight; the next request can be accepted once the result
// enters the response register, even while that result still waits.
// Reset empties the list and selects keep-order; no clearing pass runs.
// When the receiver stalls, the response holds and a finished operation waits
// until the response register frees up.
`default_nettype none
module self_organizing_list (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  sol_req_if.sink          req_i,
  sol_rsp_if.source        rsp_o
);

  logic [1:0]                 policy;
  sol_pkg::mem_req_t          mem_req;
  logic [sol_pkg::DATA_W-1:0] mem_rdata;

  sol_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .policy_o (policy)
  );

  sol_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .policy_i (policy),
    .req_i    (req_i),
    .rsp_o    (rsp_o),
    .mem_o    (mem_req),
    .rdata_i  (mem_rdata)
  );

  sol_ram #(
    .DEPTH (sol_pkg::CAPACITY),
    .WIDTH (sol_pkg::DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule
`default_nettype wire
